// ===== hdl/dsba_pkg.sv =====
// Package for the disk sector bitmap allocator.
// Holds widths, codes, map word and port structs, and zone and mask helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dsba_pkg;

  localparam int NUM_TRACKS = 35;
  localparam int DIR_TRACK  = 18;
  localparam int TRK_W      = 6;
  localparam int SEC_W      = 5;
  localparam int BITS_W     = 21;
  localparam int CNT_W      = 5;
  localparam int TOTAL_W    = 10;
  localparam int TRK_IDX_W  = $clog2(NUM_TRACKS);
  localparam int STEP_W     = $clog2(NUM_TRACKS + 1);

  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE  = 2'd1;
  localparam logic [1:0] KIND_FIND  = 2'd2;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_SAME = 2'd1;
  localparam logic [1:0] STAT_NONE = 2'd2;
  localparam logic [1:0] STAT_BAD  = 2'd3;

  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [BITS_W-1:0] bits;
  } map_word_t;

  typedef struct packed {
    logic                 en;
    logic [TRK_IDX_W-1:0] addr;
  } map_rd_t;

  typedef struct packed {
    logic                 en;
    logic [TRK_IDX_W-1:0] addr;
    map_word_t            word;
  } map_wr_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               was_free;
    logic [TRK_W-1:0]   found_track;
    logic [SEC_W-1:0]   found_sector;
    logic [TOTAL_W-1:0] blocks_free;
  } res_t;

  function automatic logic [CNT_W-1:0] zone_count(input logic [TRK_W-1:0] t);
    logic [CNT_W-1:0] c;
    if (t <= TRK_W'(17)) begin
      c = CNT_W'(21);
    end else if (t <= TRK_W'(24)) begin
      c = CNT_W'(19);
    end else if (t <= TRK_W'(30)) begin
      c = CNT_W'(18);
    end else begin
      c = CNT_W'(17);
    end
    return c;
  endfunction

  function automatic logic [BITS_W-1:0] low_mask(input logic [SEC_W-1:0] n);
    logic [BITS_W-1:0] m;
    for (int i = 0; i < BITS_W; i++) begin
      m[i] = (SEC_W'(i) < n);
    end
    return m;
  endfunction

  function automatic logic [SEC_W-1:0] lowest_bit(input logic [BITS_W-1:0] v);
    logic [SEC_W-1:0] r;
    r = '0;
    for (int i = BITS_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = SEC_W'(i);
      end
    end
    return r;
  endfunction

  function automatic map_word_t init_word(input logic [TRK_IDX_W-1:0] idx);
    map_word_t        w;
    logic [TRK_W-1:0] t;
    t = TRK_W'(idx) + TRK_W'(1);
    if (t == TRK_W'(DIR_TRACK)) begin
      w = '0;
    end else begin
      w.count = zone_count(t);
      w.bits  = low_mask(zone_count(t));
    end
    return w;
  endfunction

  function automatic logic [TOTAL_W-1:0] init_total();
    logic [TOTAL_W-1:0] s;
    s = '0;
    for (int t = 1; t <= NUM_TRACKS; t++) begin
      if (t != DIR_TRACK) begin
        s = s + TOTAL_W'(zone_count(TRK_W'(t)));
      end
    end
    return s;
  endfunction

  localparam logic [TOTAL_W-1:0] TOTAL_RESET = init_total();

endpackage

`default_nettype wire

// ===== hdl/dsba_map.sv =====
// Track map store: one word per track with free bits and free count.
// Synchronous memory with registered read; never-written entries read as reset value.
// Depends on dsba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dsba_map
  import dsba_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire map_rd_t   rd_i,
  input  wire map_wr_t   wr_i,
  output map_word_t      rd_word_o
);

  map_word_t              mem_q [NUM_TRACKS];
  logic [NUM_TRACKS-1:0]  written_q;
  map_word_t              rd_word_q;
  logic [TRK_IDX_W-1:0]   rd_addr_q;
  logic                   rd_init_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (wr_i.en) begin
      written_q[wr_i.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.word;
    end
    if (rd_i.en) begin
      rd_word_q <= mem_q[rd_i.addr];
      rd_addr_q <= rd_i.addr;
      rd_init_q <= !written_q[rd_i.addr];
    end
  end

  assign rd_word_o = rd_init_q ? init_word(rd_addr_q) : rd_word_q;

endmodule

`default_nettype wire

// ===== hdl/dsba_seq.sv =====
// Sequencer: decodes an item, reads the track map, updates it or scans for a free sector.
// Holds the free total and the pending result.
// Depends on dsba_pkg and drives dsba_map.
`timescale 1ns / 1ps
`default_nettype none

module dsba_seq
  import dsba_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  input  wire logic [1:0]        kind_i,
  input  wire logic [TRK_W-1:0]  track_i,
  input  wire logic [SEC_W-1:0]  sector_i,
  output map_rd_t                rd_o,
  output map_wr_t                wr_o,
  input  wire map_word_t         rd_word_i,
  output      logic              res_valid_o,
  input  wire logic              res_ready_i,
  output res_t                   res_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_TRACKS);

  logic [1:0]         state_q, state_d;
  logic [1:0]         kind_q, kind_d;
  logic [TRK_W-1:0]   trk_q, trk_d;
  logic [SEC_W-1:0]   sec_q, sec_d;
  logic [TRK_W-1:0]   cur_q, cur_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  res_t               res_q, res_d;

  logic               addr_ok;
  logic               was_bit;
  logic [BITS_W-1:0]  scan_mask;
  logic [BITS_W-1:0]  hits;
  logic [TRK_W-1:0]   cur_next;
  logic               not_dir;

  assign addr_ok = (kind_i inside {KIND_ALLOC, KIND_FREE, KIND_FIND})
                && (track_i != '0) && (track_i <= TRK_W'(NUM_TRACKS))
                && (sector_i < zone_count(track_i));
  assign was_bit  = rd_word_i.bits[sec_q];
  assign not_dir  = (trk_q != TRK_W'(DIR_TRACK));
  assign cur_next = (cur_q == TRK_W'(NUM_TRACKS)) ? TRK_W'(1) : cur_q + TRK_W'(1);

  always_comb begin
    if (step_q == '0) begin
      scan_mask = low_mask(zone_count(cur_q)) & ~low_mask(sec_q);
    end else if (step_q == LAST_STEP) begin
      scan_mask = low_mask(sec_q);
    end else begin
      scan_mask = low_mask(zone_count(cur_q));
    end
    hits = rd_word_i.bits & scan_mask;
  end

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    trk_d       = trk_q;
    sec_d       = sec_q;
    cur_d       = cur_q;
    step_d      = step_q;
    total_d     = total_q;
    res_d       = res_q;
    rd_o        = '0;
    wr_o        = '0;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          kind_d = kind_i;
          trk_d  = track_i;
          sec_d  = sector_i;
          cur_d  = track_i;
          step_d = '0;
          res_d  = '0;
          res_d.blocks_free = total_q;
          if (!addr_ok) begin
            res_d.status = STAT_BAD;
            state_d      = S_DONE;
          end else begin
            rd_o.en   = 1'b1;
            rd_o.addr = TRK_IDX_W'(track_i - TRK_W'(1));
            state_d   = (kind_i == KIND_FIND) ? S_SCAN : S_READ;
          end
        end
      end
      S_READ: begin
        res_d.was_free = was_bit;
        wr_o.addr      = TRK_IDX_W'(trk_q - TRK_W'(1));
        wr_o.word      = rd_word_i;
        if ((kind_q == KIND_ALLOC) == was_bit) begin
          wr_o.en                = 1'b1;
          wr_o.word.bits[sec_q]  = !was_bit;
          res_d.status           = STAT_OK;
          if (was_bit) begin
            wr_o.word.count = rd_word_i.count - CNT_W'(1);
            if (not_dir) begin
              total_d = total_q - TOTAL_W'(1);
            end
          end else begin
            wr_o.word.count = rd_word_i.count + CNT_W'(1);
            if (not_dir) begin
              total_d = total_q + TOTAL_W'(1);
            end
          end
        end else begin
          res_d.status = STAT_SAME;
        end
        res_d.blocks_free = total_d;
        state_d = S_DONE;
      end
      S_SCAN: begin
        if (step_q == '0) begin
          res_d.was_free = was_bit;
        end
        if (hits != '0) begin
          res_d.status       = STAT_OK;
          res_d.found_track  = cur_q;
          res_d.found_sector = lowest_bit(hits);
          state_d            = S_DONE;
        end else if (step_q == LAST_STEP) begin
          res_d.status = STAT_NONE;
          state_d      = S_DONE;
        end else begin
          cur_d     = cur_next;
          step_d    = step_q + STEP_W'(1);
          rd_o.en   = 1'b1;
          rd_o.addr = TRK_IDX_W'(cur_next - TRK_W'(1));
        end
      end
      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      total_q <= TOTAL_RESET;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    trk_q  <= trk_d;
    sec_q  <= sec_d;
    cur_q  <= cur_d;
    step_q <= step_d;
    res_q  <= res_d;
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

// ===== hdl/disk_sector_bitmap_allocator.sv =====
// A search reads one track word per cycle from the map.
// Throughput: one item at a time; the next item is taken once the sequencer is idle,
// while the previous result may still wait in the output register.
// Reset: all sectors free except track 18, free total 664; no clearing pass.
// Top level of the disk sector bitmap allocator; depends on dsba_pkg, dsba_map, dsba_seq.
`timescale 1ns / 1ps
`default_nettype none

module disk_sector_bitmap_allocator
  import dsba_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // track[5:0], sector[10:6], zero[15:11]
  input  wire logic [1:0]  s_axis_tuser,  // kind[1:0]
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [23:0] m_axis_tdata,  // was_free[0], found_track[6:1],
                                          // found_sector[11:7], blocks_free[21:12],
                                          // zero[23:22]
  output      logic [1:0]  m_axis_tuser   // status[1:0]
);

  map_rd_t   map_rd;
  map_wr_t   map_wr;
  map_word_t map_word;
  logic      res_valid;
  logic      res_ready;
  res_t      res;
  logic      out_valid_q;
  res_t      out_q;

  dsba_map u_map (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_i      (map_rd),
    .wr_i      (map_wr),
    .rd_word_o (map_word)
  );

  dsba_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .kind_i      (s_axis_tuser),
    .track_i     (s_axis_tdata[5:0]),
    .sector_i    (s_axis_tdata[10:6]),
    .rd_o        (map_rd),
    .wr_o        (map_wr),
    .rd_word_i   (map_word),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {2'b00, out_q.blocks_free, out_q.found_sector,
                          out_q.found_track, out_q.was_free};

endmodule

`default_nettype wire

// ===== hdl/dsba_checker.sv =====
// Port checker for the disk sector bitmap allocator, bound to the top level.
// Depends on dsba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dsba_checker
  import dsba_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second beat taken while an item is in work");

  a_bad_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == STAT_BAD) |-> (m_axis_tdata[11:0] == '0))
    else $error("bad address result carries data");

  a_none_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == STAT_NONE) |-> (m_axis_tdata[11:1] == '0))
    else $error("failed search reports a position");

  a_total_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[21:12] <= TOTAL_RESET) && (m_axis_tdata[23:22] == '0))
    else $error("free total out of range");

endmodule

bind disk_sector_bitmap_allocator dsba_checker u_dsba_checker (.*);

`default_nettype wire
